>>> rtl/core/inverse_park_minmax_svpwm_core_defines.svh
// Assertion macros shared by the inverse Park / min-max SVPWM core RTL.
// Needs signals named clk and arst_n in the module that uses a macro.
`ifndef INVERSE_PARK_MINMAX_SVPWM_CORE_DEFINES_SVH
`define INVERSE_PARK_MINMAX_SVPWM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IPMS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ipms assertion failed");
`define IPMS_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ipms forbidden condition seen");
`else
`define IPMS_ASSERT(lbl, prop)
`define IPMS_ASSERT_NEVER(lbl, expr)
`endif
`endif

>>> rtl/core/ipms_pkg.sv
// Package of the inverse Park / min-max SVPWM core: widths, constants, register indexes.
// No dependencies.
`timescale 1ns / 1ps
package ipms_pkg;
	localparam int VOLT_WIDTH_DEF = 16;
	localparam int NUM_EXTRA      = 18;   // numerator bits beyond the voltage width
	localparam int LANES          = 2;    // alpha and beta
	localparam int QUO_BITS       = 25;   // quotient magnitude bits
	localparam int QUO_W          = QUO_BITS + 1;
	localparam int DUTY_W         = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int SQRT3_HALF_Q16 = 56756;
	localparam int HALF_Q16       = 32768;

	localparam logic [QUO_BITS-1:0] NORM_LIMIT = QUO_BITS'(1 << 24);

	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL_COUNT = 2'd2;

	localparam logic [CFG_W-1:0] DUTY_FLOOR_RST     = 16'd0;
	localparam logic [CFG_W-1:0] DUTY_CEILING_RST   = 16'd65535;
	localparam logic [CFG_W-1:0] PWM_FULL_COUNT_RST = 16'd4096;
endpackage

>>> rtl/core/ipms_cmd_if.sv
// Command channel of the SVPWM core: d/q voltages, angle sine/cosine, bus voltage.
// Depends on ipms_pkg for the default voltage width.
`timescale 1ns / 1ps
interface ipms_cmd_if #(parameter int VOLT_WIDTH = ipms_pkg::VOLT_WIDTH_DEF) ();
	logic                         valid;
	logic                         ready;
	logic signed [VOLT_WIDTH-1:0] volt_d;
	logic signed [VOLT_WIDTH-1:0] volt_q;
	logic signed [15:0]           sine_angle;
	logic signed [15:0]           cosine_angle;
	logic        [VOLT_WIDTH-1:0] bus_voltage;

	modport source (output valid, volt_d, volt_q, sine_angle, cosine_angle, bus_voltage,
		input ready);
	modport sink (input valid, volt_d, volt_q, sine_angle, cosine_angle, bus_voltage,
		output ready);
endinterface

>>> rtl/core/ipms_pwm_if.sv
// Result channel of the SVPWM core: three compare counts and three phase voltages.
// No dependencies.
`timescale 1ns / 1ps
interface ipms_pwm_if ();
	logic        valid;
	logic        ready;
	logic [15:0] count_u;
	logic [15:0] count_v;
	logic [15:0] count_w;
	logic [15:0] phase_volt_u;
	logic [15:0] phase_volt_v;
	logic [15:0] phase_volt_w;

	modport source (output valid, count_u, count_v, count_w,
		phase_volt_u, phase_volt_v, phase_volt_w, input ready);
	modport sink (input valid, count_u, count_v, count_w,
		phase_volt_u, phase_volt_v, phase_volt_w, output ready);
endinterface

>>> rtl/core/ipms_div.sv
// Two-lane pipelined restoring divider: |2*v| / bus, truncated, saturated to +-2^24.
// Depends on ipms_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "inverse_park_minmax_svpwm_core_defines.svh"
module ipms_div #(
	parameter int VOLT_WIDTH = ipms_pkg::VOLT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [VOLT_WIDTH+ipms_pkg::NUM_EXTRA-1:0] num_mag [ipms_pkg::LANES],
	input  logic [ipms_pkg::LANES-1:0]               num_neg,
	input  logic [VOLT_WIDTH-1:0]                    bus_in,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [ipms_pkg::QUO_W-1:0]        quo [ipms_pkg::LANES],
	output logic [VOLT_WIDTH-1:0]                    bus_out
);
	import ipms_pkg::*;

	localparam int W     = VOLT_WIDTH;
	localparam int NUM_W = VOLT_WIDTH + NUM_EXTRA;
	localparam int QB    = QUO_BITS;
	localparam logic signed [QUO_W-1:0] LIM_POS = $signed({1'b0, NORM_LIMIT});
	localparam logic signed [QUO_W-1:0] LIM_NEG = -LIM_POS;

	logic [QB:0] v_s;
	logic [QB:0] en_s;
	logic        v_sx;
	logic        en_x;

	logic [W-1:0]     rem_s [QB+1][LANES];
	logic [QB-1:0]    wrk_s [QB+1][LANES];
	logic [LANES-1:0] ovf_s [QB+1];
	logic [LANES-1:0] nz_s  [QB+1];
	logic [LANES-1:0] neg_s [QB+1];
	logic [W-1:0]     bus_s [QB+1];

	logic signed [QUO_W-1:0] quo_sx [LANES];
	logic [W-1:0]            bus_sx;

	// advance a stage when it is empty or its successor advances
	assign en_x     = !v_sx || out_ready;
	assign in_ready = en_s[0];

	for (genvar k = 0; k <= QB; k++) begin : g_en
		if (k == QB) begin : g_last
			assign en_s[k] = !v_s[k] || en_x;
		end else begin : g_mid
			assign en_s[k] = !v_s[k] || en_s[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s  <= '0;
			v_sx <= 1'b0;
		end else begin
			if (en_s[0]) begin
				v_s[0] <= in_valid;
			end
			for (int k = 1; k <= QB; k++) begin
				if (en_s[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
			if (en_x) begin
				v_sx <= v_s[QB];
			end
		end
	end

	// entry: top numerator bits against the bus catch saturation
	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			for (int l = 0; l < LANES; l++) begin
				ovf_s[0][l] <= (W+1)'(num_mag[l][NUM_W-1:QB]) >= (W+1)'(bus_in);
				rem_s[0][l] <= W'(num_mag[l][NUM_W-1:QB]);
				wrk_s[0][l] <= num_mag[l][QB-1:0];
				nz_s[0][l]  <= |num_mag[l];
			end
			neg_s[0] <= num_neg;
			bus_s[0] <= bus_in;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= QB; k++) begin : g_step
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [W:0] trial;
			logic       ge;
			assign trial = {rem_s[k-1][l], wrk_s[k-1][l][QB-1]};
			assign ge    = trial >= {1'b0, bus_s[k-1]};
			always_ff @(posedge clk) begin
				if (en_s[k]) begin
					rem_s[k][l] <= ge ? W'(trial - {1'b0, bus_s[k-1]}) : trial[W-1:0];
					wrk_s[k][l] <= {wrk_s[k-1][l][QB-2:0], ge};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				ovf_s[k] <= ovf_s[k-1];
				nz_s[k]  <= nz_s[k-1];
				neg_s[k] <= neg_s[k-1];
				bus_s[k] <= bus_s[k-1];
			end
		end
	end

	// clamp, apply sign, drop a zero numerator to zero
	always_ff @(posedge clk) begin
		if (en_x) begin
			for (int l = 0; l < LANES; l++) begin
				logic [QB-1:0] mag;
				mag = (ovf_s[QB][l] || wrk_s[QB][l] > NORM_LIMIT) ? NORM_LIMIT : wrk_s[QB][l];
				if (!nz_s[QB][l]) begin
					quo_sx[l] <= '0;
				end else if (neg_s[QB][l]) begin
					quo_sx[l] <= -$signed({1'b0, mag});
				end else begin
					quo_sx[l] <= $signed({1'b0, mag});
				end
			end
			bus_sx <= bus_s[QB];
		end
	end

	assign out_valid = v_sx;
	assign quo       = quo_sx;
	assign bus_out   = bus_sx;

	`IPMS_ASSERT(a_quo_range, v_sx |-> (quo_sx[0] <= LIM_POS && quo_sx[0] >= LIM_NEG && quo_sx[1] <= LIM_POS && quo_sx[1] >= LIM_NEG))
	`IPMS_ASSERT(a_rem_below_bus, (v_s[QB] && !ovf_s[QB][0]) |-> (rem_s[QB][0] < bus_s[QB]))
	`IPMS_ASSERT(a_stall_needs_item, !in_ready |-> v_s[0])
endmodule

>>> rtl/core/inverse_park_minmax_svpwm_core.sv
// Top level of the inverse Park / min-max zero-sequence SVPWM core.
// Depends on ipms_pkg, ipms_cmd_if, ipms_pwm_if, ipms_div and the macro header.
//
//   channel   | dir  | handshake    | payload
//   ----------+------+--------------+-------------------------------------------------
//   command   | sink | valid/ready  | volt_d, volt_q, sine_angle, cosine_angle, bus_voltage
//   pwm       | src  | valid/ready  | count_u/v/w, phase_volt_u/v/w
//   cfg       | sink | cfg_wr_en    | cfg_index, cfg_wdata (no read-back)
//
// Takes one request per cycle while pwm is ready; the pipe is the 27-stage divider
// (each bit stage making one quotient bit) plus eight datapath stages.
// Reset clears the valid bits and loads the register defaults; no sweep is needed.
// Each stage advances when empty or when its successor advances, so bubbles
// collapse and a stalled pwm channel fills the pipe before command.ready drops.
`timescale 1ns / 1ps
`include "inverse_park_minmax_svpwm_core_defines.svh"
module inverse_park_minmax_svpwm_core #(
	parameter int VOLT_WIDTH = ipms_pkg::VOLT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ipms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipms_pkg::CFG_W-1:0]     cfg_wdata,
	ipms_cmd_if.sink                       command,
	ipms_pwm_if.source                     pwm
);
	import ipms_pkg::*;

	localparam int W     = VOLT_WIDTH;
	localparam int PR_W  = W + 16;          // d/q times sin/cos
	localparam int AB_W  = W + 17;          // alpha, beta
	localparam int NUM_W = W + NUM_EXTRA;   // 2*|alpha| with headroom
	localparam int PB_W  = 44;              // sqrt3/2 times beta, Q.16
	localparam int PH_W  = PB_W - 16;       // phase values
	localparam int UD_W  = PH_W + 2;        // duty before limiting
	localparam int PV_W  = DUTY_W + W;

	// configuration registers
	logic [CFG_W-1:0] duty_floor_q;
	logic [CFG_W-1:0] duty_ceiling_q;
	logic [CFG_W-1:0] pwm_full_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_floor_q     <= DUTY_FLOOR_RST;
			duty_ceiling_q   <= DUTY_CEILING_RST;
			pwm_full_count_q <= PWM_FULL_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DUTY_FLOOR:     duty_floor_q     <= cfg_wdata;
				CFG_DUTY_CEILING:   duty_ceiling_q   <= cfg_wdata;
				CFG_PWM_FULL_COUNT: pwm_full_count_q <= cfg_wdata;
				default: ;  // drop writes to unmapped indexes
			endcase
		end
	end

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic div_in_ready, div_out_valid;

	assign en8 = !v_s8 || pwm.ready;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || div_in_ready;
	assign en1 = !v_s1 || en2;
	assign command.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= command.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= div_out_valid;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// S1: the four rotation products
	logic signed [PR_W-1:0] pdc_s1, pqs_s1, pds_s1, pqc_s1;
	logic [W-1:0]           bus_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			pdc_s1 <= command.volt_d * command.cosine_angle;
			pqs_s1 <= command.volt_q * command.sine_angle;
			pds_s1 <= command.volt_d * command.sine_angle;
			pqc_s1 <= command.volt_q * command.cosine_angle;
			bus_s1 <= command.bus_voltage;
		end
	end

	// S2: alpha/beta, split into sign and doubled magnitude for the divider
	logic signed [AB_W-1:0] alpha_c, beta_c;
	logic [AB_W-1:0]        alpha_abs, beta_abs;
	logic [NUM_W-1:0]       mag_s2 [LANES];
	logic [LANES-1:0]       neg_s2;
	logic [W-1:0]           bus_s2;

	assign alpha_c   = AB_W'(pdc_s1) - AB_W'(pqs_s1);
	assign beta_c    = AB_W'(pds_s1) + AB_W'(pqc_s1);
	assign alpha_abs = alpha_c[AB_W-1] ? AB_W'(-alpha_c) : AB_W'(alpha_c);
	assign beta_abs  = beta_c[AB_W-1] ? AB_W'(-beta_c) : AB_W'(beta_c);

	always_ff @(posedge clk) begin
		if (en2) begin
			mag_s2[0] <= {alpha_abs, 1'b0};
			mag_s2[1] <= {beta_abs, 1'b0};
			neg_s2    <= {beta_c[AB_W-1], alpha_c[AB_W-1]};
			bus_s2    <= bus_s1;
		end
	end

	// normalize both lanes by the bus voltage
	logic signed [QUO_W-1:0] quo_d [LANES];
	logic [W-1:0]            bus_d;

	ipms_div #(
		.VOLT_WIDTH(VOLT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.in_ready (div_in_ready),
		.num_mag  (mag_s2),
		.num_neg  (neg_s2),
		.bus_in   (bus_s2),
		.out_valid(div_out_valid),
		.out_ready(en3),
		.quo      (quo_d),
		.bus_out  (bus_d)
	);

	// S3: sqrt(3)/2 times beta
	logic signed [QUO_W-1:0] a_s3;
	logic signed [PB_W-1:0]  pb_s3;
	logic [W-1:0]            bus_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			a_s3   <= quo_d[0];
			pb_s3  <= quo_d[1] * $signed(18'(SQRT3_HALF_Q16));
			bus_s3 <= bus_d;
		end
	end

	// S4: inverse Clarke, round half up on the Q.16 drop
	logic signed [PB_W-1:0] half_a, rv_c, rw_c;
	logic signed [PH_W-1:0] ph_s4 [3];
	logic [W-1:0]           bus_s4;

	assign half_a = PB_W'(a_s3) <<< 15;
	assign rv_c   = pb_s3 - half_a + PB_W'(HALF_Q16);
	assign rw_c   = -pb_s3 - half_a + PB_W'(HALF_Q16);

	always_ff @(posedge clk) begin
		if (en4) begin
			ph_s4[0] <= PH_W'(a_s3);
			ph_s4[1] <= rv_c[PB_W-1:16];
			ph_s4[2] <= rw_c[PB_W-1:16];
			bus_s4   <= bus_s3;
		end
	end

	// S5: zero-sequence offset, floor of the max/min mean
	logic signed [PH_W-1:0] mx_c, mn_c;
	logic signed [PH_W:0]   mm_sum;
	logic signed [PH_W-1:0] off_c;
	logic signed [PH_W-1:0] ph_s5 [3];
	logic signed [PH_W-1:0] off_s5;
	logic [W-1:0]           bus_s5;

	always_comb begin
		mx_c = ph_s4[0];
		mn_c = ph_s4[0];
		for (int k = 1; k < 3; k++) begin
			if (ph_s4[k] > mx_c) mx_c = ph_s4[k];
			if (ph_s4[k] < mn_c) mn_c = ph_s4[k];
		end
	end
	assign mm_sum = (PH_W+1)'(mx_c) + (PH_W+1)'(mn_c);
	assign off_c  = mm_sum[PH_W:1];

	always_ff @(posedge clk) begin
		if (en5) begin
			ph_s5  <= ph_s4;
			off_s5 <= off_c;
			bus_s5 <= bus_s4;
		end
	end

	// S6: recenter and limit; the ceiling wins over the floor
	logic signed [UD_W-1:0] floor_x, ceil_x;
	logic [DUTY_W-1:0]      duty_c [3];
	logic [DUTY_W-1:0]      duty_s6 [3];
	logic [W-1:0]           bus_s6;

	assign floor_x = $signed({{(UD_W-CFG_W){1'b0}}, duty_floor_q});
	assign ceil_x  = $signed({{(UD_W-CFG_W){1'b0}}, duty_ceiling_q});

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [UD_W-1:0] ud;
			ud = UD_W'(ph_s5[k]) - UD_W'(off_s5) + UD_W'(HALF_Q16);
			if (ud < floor_x) ud = floor_x;
			if (ud > ceil_x) ud = ceil_x;
			duty_c[k] = ud[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			duty_s6 <= duty_c;
			bus_s6  <= bus_s5;
		end
	end

	// S7: scale each duty by the full count and by the bus voltage
	logic [2*DUTY_W-1:0] cntp_s7 [3];
	logic [PV_W-1:0]     pvp_s7 [3];

	always_ff @(posedge clk) begin
		if (en7) begin
			for (int k = 0; k < 3; k++) begin
				cntp_s7[k] <= (2*DUTY_W)'(duty_s6[k]) * (2*DUTY_W)'(pwm_full_count_q);
				pvp_s7[k]  <= PV_W'(duty_s6[k]) * PV_W'(bus_s6);
			end
		end
	end

	// S8: output register; saturate phase voltage above 16 bits
	logic [15:0] count_s8 [3];
	logic [15:0] pvolt_s8 [3];

	always_ff @(posedge clk) begin
		if (en8) begin
			for (int k = 0; k < 3; k++) begin
				logic [W-1:0] pvs;
				pvs = pvp_s7[k][PV_W-1:DUTY_W];
				count_s8[k] <= cntp_s7[k][2*DUTY_W-1:DUTY_W];
				pvolt_s8[k] <= (33'(pvs) > 33'(16'hFFFF)) ? 16'hFFFF : 16'(pvs);
			end
		end
	end

	assign pwm.valid        = v_s8;
	assign pwm.count_u      = count_s8[0];
	assign pwm.count_v      = count_s8[1];
	assign pwm.count_w      = count_s8[2];
	assign pwm.phase_volt_u = pvolt_s8[0];
	assign pwm.phase_volt_v = pvolt_s8[1];
	assign pwm.phase_volt_w = pvolt_s8[2];

	`IPMS_ASSERT(a_ready_low_means_full, !command.ready |-> v_s1)
	`IPMS_ASSERT(a_offset_between, v_s4 |-> (mx_c >= off_c && mn_c <= off_c))
	`IPMS_ASSERT(a_duty_in_limits, (v_s5 && duty_floor_q <= duty_ceiling_q) |-> (duty_c[0] >= duty_floor_q && duty_c[0] <= duty_ceiling_q && duty_c[1] >= duty_floor_q && duty_c[1] <= duty_ceiling_q && duty_c[2] >= duty_floor_q && duty_c[2] <= duty_ceiling_q))
	`IPMS_ASSERT_NEVER(a_no_stage_skip, en3 && !div_out_valid && v_s3 && !en4)
endmodule
